@@ design/swik_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Swerve wheel inverse kinematics package
// Shared constants, state encoding and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package swik_pkg;

   localparam int MAX_WHEELS        = 8;
   localparam int WHEEL_W           = $clog2(MAX_WHEELS);
   localparam int CORDIC_ITERATIONS = 16;
   localparam int COEF_DEPTH        = MAX_WHEELS * 6;
   localparam int COEF_AW           = $clog2(COEF_DEPTH);
   localparam int SQRT_STEPS        = 32;
   localparam int STEP_W            = 5;
   localparam int CORDIC_W          = 52;

   localparam logic CSR_HOLD_THRESH = 1'b0;
   localparam logic CSR_WHEEL_COUNT = 1'b1;
   localparam logic ACT_VELOCITY    = 1'b0;
   localparam logic ACT_COEF_WRITE  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COEF,
      ST_SQX,
      ST_SQY,
      ST_SOLVE,
      ST_DONE
   } state_type;

   function automatic logic [31:0] atan_units(input logic [STEP_W-1:0] idx);
      logic [31:0] r;
      case (idx)
         5'd0:    r = 32'd536870912;
         5'd1:    r = 32'd316933406;
         5'd2:    r = 32'd167458907;
         5'd3:    r = 32'd85004756;
         5'd4:    r = 32'd42667331;
         5'd5:    r = 32'd21354465;
         5'd6:    r = 32'd10679838;
         5'd7:    r = 32'd5340245;
         5'd8:    r = 32'd2670163;
         5'd9:    r = 32'd1335087;
         5'd10:   r = 32'd667544;
         5'd11:   r = 32'd333772;
         5'd12:   r = 32'd166886;
         5'd13:   r = 32'd83443;
         5'd14:   r = 32'd41722;
         5'd15:   r = 32'd20861;
         5'd16:   r = 32'd10430;
         5'd17:   r = 32'd5215;
         5'd18:   r = 32'd2608;
         5'd19:   r = 32'd1304;
         5'd20:   r = 32'd652;
         5'd21:   r = 32'd326;
         5'd22:   r = 32'd163;
         5'd23:   r = 32'd81;
         default: r = 32'd0;
      endcase
      return r;
   endfunction

endpackage

@@ design/swik_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module swik_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 48
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

@@ design/swerve_wheel_inverse_kinematics_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Swerve wheel inverse kinematics
// Turns a chassis velocity command into per-wheel speed and steering angle.
// ----------------------------------------------------------------------------
// The req channel carries one beat per command. A coefficient write beat
// (req_action high) stores one Q16.16 matrix entry and returns nothing. A
// velocity beat produces one rsp beat per configured wheel, wheel 0 first,
// with rsp_last on the final wheel. The csr channel writes the hold threshold
// (index 0) and the wheel count (index 1) and is always ready.
// Each wheel runs these steps in order: its six coefficients stream from
// the coefficient RAM through the multiplier, states ST_SQX and ST_SQY
// square the components, 32 steps of the bit-serial square root run with
// the 16 CORDIC steps beside them, and the output register is loaded.
// The next req beat is taken in the cycle after the last result is loaded.
// If the receiver stalls, the finished result waits in the output register
// and the engine stops before overwriting it. Reset clears the held steering
// angles, sets the wheel count to four and the hold threshold to zero; the
// coefficient RAM is not cleared and must be written before use.
// ----------------------------------------------------------------------------
module swerve_wheel_inverse_kinematics_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_action,
   input  logic signed [31:0]          req_vel_x,
   input  logic signed [31:0]          req_vel_y,
   input  logic signed [31:0]          req_yaw_rate,
   input  logic [2:0]                  req_coef_wheel,
   input  logic [2:0]                  req_coef_slot,
   input  logic signed [31:0]          req_coef_value,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [2:0]                  rsp_wheel_index,
   output logic signed [15:0]          rsp_wheel_dir,
   output logic [31:0]                 rsp_wheel_speed,
   output logic                        rsp_last,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic                        csr_index,
   input  logic [31:0]                 csr_data
);
   import swik_pkg::*;

   localparam logic signed [49:0] SAT_MAX = 50'sd2147483647;
   localparam logic signed [49:0] SAT_MIN = -50'sd2147483648;

   state_type state_ff, state_in;

   logic [31:0]                hold_thresh_ff;
   logic [3:0]                 count_ff, count_in;
   logic signed [31:0]         vx_ff, vy_ff, yaw_ff;
   logic [WHEEL_W-1:0]         wheel_ff, wheel_in;
   logic [2:0]                 slot_ff, slot_in;
   logic                       rd_vld_ff;
   logic [2:0]                 rd_slot_ff;
   logic                       prod_vld_ff;
   logic [2:0]                 prod_slot_ff;
   logic signed [63:0]         prod_ff, prod_in;
   logic signed [49:0]         acc_ff, acc_in, sum;
   logic signed [31:0]         comp_x_ff, comp_y_ff, sat_v;
   logic [63:0]                sqx_ff;
   logic signed [63:0]         sqx_s, sqy_s;
   logic [63:0]                rem_ff, root_ff, bitv, trial;
   logic [STEP_W-1:0]          iter_ff;
   logic signed [CORDIC_W-1:0] cx_ff, cy_ff, x0, y0, xs, ys;
   logic [31:0]                ang_ff, ang_rnd;
   logic [MAX_WHEELS-1:0]      held_vld_ff;
   logic                       rsp_valid_ff;
   logic [2:0]                 rsp_index_ff;
   logic [15:0]                rsp_dir_ff;
   logic [31:0]                rsp_speed_ff;
   logic                       rsp_last_ff;

   logic                       req_fire, load_out, issue, coef_wr;
   logic [COEF_AW-1:0]         coef_wr_addr, coef_rd_addr;
   logic [31:0]                coef_q;
   logic [15:0]                held_q, held_cur, dir_new;
   logic signed [31:0]         cmd_sel;
   logic [31:0]                speed;
   logic                       is_last;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign coef_wr      = req_fire && (req_action == ACT_COEF_WRITE) && (req_coef_slot < 3'd6);
   assign coef_wr_addr = COEF_AW'(req_coef_wheel) * COEF_AW'(6) + COEF_AW'(req_coef_slot);
   assign issue        = (state_ff == ST_COEF) && (slot_ff < 3'd6);
   assign coef_rd_addr = COEF_AW'(wheel_ff) * COEF_AW'(6) + COEF_AW'(slot_ff);

   swik_ram #(.WIDTH(32), .DEPTH(COEF_DEPTH)) u_coef_ram (
      .clock   (clock),
      .wr_en   (coef_wr),
      .wr_addr (coef_wr_addr),
      .wr_data (req_coef_value),
      .rd_en   (issue),
      .rd_addr (coef_rd_addr),
      .rd_data (coef_q)
   );

   swik_ram #(.WIDTH(16), .DEPTH(MAX_WHEELS)) u_held_ram (
      .clock   (clock),
      .wr_en   (load_out),
      .wr_addr (wheel_ff),
      .wr_data (dir_new),
      .rd_en   (issue && (slot_ff == 3'd0)),
      .rd_addr (wheel_ff),
      .rd_data (held_q)
   );

   always_comb begin
      case (rd_slot_ff)
         3'd0, 3'd3: cmd_sel = vx_ff;
         3'd1, 3'd4: cmd_sel = vy_ff;
         default:    cmd_sel = yaw_ff;
      endcase
      prod_in = $signed(coef_q) * cmd_sel;
      sum = ((prod_slot_ff == 3'd0 || prod_slot_ff == 3'd3) ? 50'sd0 : acc_ff)
            + 50'($signed(prod_ff[63:16]));
      if (sum > SAT_MAX) begin
         sat_v = 32'sh7FFF_FFFF;
      end else if (sum < SAT_MIN) begin
         sat_v = 32'sh8000_0000;
      end else begin
         sat_v = sum[31:0];
      end
      acc_in = sum;
   end

   assign sqx_s = comp_x_ff * comp_x_ff;
   assign sqy_s = comp_y_ff * comp_y_ff;

   assign x0    = CORDIC_W'(comp_x_ff) <<< 16;
   assign y0    = CORDIC_W'(comp_y_ff) <<< 16;
   assign xs    = cx_ff >>> iter_ff;
   assign ys    = cy_ff >>> iter_ff;
   assign bitv  = 64'h4000_0000_0000_0000 >> {iter_ff, 1'b0};
   assign trial = root_ff + bitv;

   assign speed    = root_ff[31:0];
   assign ang_rnd  = ang_ff + 32'h0000_8000;
   assign held_cur = held_vld_ff[wheel_ff] ? held_q : 16'd0;
   assign dir_new  = (speed > hold_thresh_ff) ? ang_rnd[31:16] : held_cur;
   assign is_last  = (4'(wheel_ff) + 4'd1 == count_ff);
   assign load_out = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      wheel_in = wheel_ff;
      slot_in  = slot_ff;
      if (issue) begin
         slot_in = slot_ff + 3'd1;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_action == ACT_VELOCITY) begin
               state_in = ST_COEF;
               wheel_in = '0;
               slot_in  = 3'd0;
            end
         end
         ST_COEF: begin
            if (prod_vld_ff && prod_slot_ff == 3'd5) begin
               state_in = ST_SQX;
            end
         end
         ST_SQX:   state_in = ST_SQY;
         ST_SQY:   state_in = ST_SOLVE;
         ST_SOLVE: begin
            if (iter_ff == STEP_W'(SQRT_STEPS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (load_out) begin
               if (is_last) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_COEF;
                  wheel_in = wheel_ff + WHEEL_W'(1);
                  slot_in  = 3'd0;
               end
            end
         end
         default:  state_in = ST_IDLE;
      endcase
      if (csr_valid && csr_ready && csr_index == CSR_WHEEL_COUNT) begin
         if (csr_data[3:0] < 4'd2) begin
            count_in = 4'd2;
         end else if (csr_data[3:0] > 4'(MAX_WHEELS)) begin
            count_in = 4'(MAX_WHEELS);
         end else begin
            count_in = csr_data[3:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         hold_thresh_ff <= '0;
         count_ff       <= 4'd4;
         wheel_ff       <= '0;
         slot_ff        <= 3'd6;
         rd_vld_ff      <= 1'b0;
         prod_vld_ff    <= 1'b0;
         held_vld_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
         iter_ff        <= '0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         wheel_ff    <= wheel_in;
         slot_ff     <= slot_in;
         rd_vld_ff   <= issue;
         prod_vld_ff <= rd_vld_ff;
         if (csr_valid && csr_ready && csr_index == CSR_HOLD_THRESH) begin
            hold_thresh_ff <= csr_data;
         end
         if (state_ff == ST_SQY) begin
            iter_ff <= '0;
         end else if (state_ff == ST_SOLVE) begin
            iter_ff <= iter_ff + STEP_W'(1);
         end
         if (load_out) begin
            held_vld_ff[wheel_ff] <= 1'b1;
            rsp_valid_ff          <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         vx_ff  <= req_vel_x;
         vy_ff  <= req_vel_y;
         yaw_ff <= req_yaw_rate;
      end
      rd_slot_ff   <= slot_ff;
      prod_slot_ff <= rd_slot_ff;
      prod_ff      <= prod_in;
      if (prod_vld_ff) begin
         acc_ff <= acc_in;
         if (prod_slot_ff == 3'd2) begin
            comp_x_ff <= sat_v;
         end
         if (prod_slot_ff == 3'd5) begin
            comp_y_ff <= sat_v;
         end
      end
      if (state_ff == ST_SQX) begin
         sqx_ff <= sqx_s;
         if (comp_x_ff < 0) begin
            cx_ff  <= -x0;
            cy_ff  <= -y0;
            ang_ff <= 32'h8000_0000;
         end else begin
            cx_ff  <= x0;
            cy_ff  <= y0;
            ang_ff <= 32'h0000_0000;
         end
      end
      if (state_ff == ST_SQY) begin
         rem_ff  <= sqx_ff + sqy_s;
         root_ff <= '0;
      end
      if (state_ff == ST_SOLVE) begin
         if (rem_ff >= trial) begin
            rem_ff  <= rem_ff - trial;
            root_ff <= (root_ff >> 1) + bitv;
         end else begin
            root_ff <= root_ff >> 1;
         end
         if (iter_ff < STEP_W'(CORDIC_ITERATIONS)) begin
            if (cy_ff > 0) begin
               cx_ff  <= cx_ff + ys;
               cy_ff  <= cy_ff - xs;
               ang_ff <= ang_ff + atan_units(iter_ff);
            end else begin
               cx_ff  <= cx_ff - ys;
               cy_ff  <= cy_ff + xs;
               ang_ff <= ang_ff - atan_units(iter_ff);
            end
         end
      end
      if (load_out) begin
         rsp_index_ff <= 3'(wheel_ff);
         rsp_dir_ff   <= dir_new;
         rsp_speed_ff <= speed;
         rsp_last_ff  <= is_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_wheel_index = rsp_index_ff;
   assign rsp_wheel_dir   = $signed(rsp_dir_ff);
   assign rsp_wheel_speed = rsp_speed_ff;
   assign rsp_last        = rsp_last_ff;

   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> state_ff == ST_IDLE)
      else $error("request beat taken while busy");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff >= 4'd2 && count_ff <= 4'(MAX_WHEELS))
      else $error("wheel count out of range");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !load_out)
      else $error("pending result overwritten");

   a_wheel_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> 4'(wheel_ff) < count_ff)
      else $error("wheel index beyond count");

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Swerve wheel inverse kinematics testbench
// Drives velocity commands and coefficient writes, predicts the per-wheel
// speed and steering angle in a scoreboard, and checks each rsp beat.
// ----------------------------------------------------------------------------
import swik_pkg::*;

class wheel_scoreboard;
   logic signed [31:0] coef [0:47];
   logic [15:0]        held [0:7];
   logic [31:0]        hold_thresh;
   logic [3:0]         wheel_count;
   logic [2:0]         exp_index[$];
   logic [15:0]        exp_dir[$];
   logic [31:0]        exp_speed[$];
   logic               exp_last[$];
   int                 mismatches;

   function new();
      for (int i = 0; i < 48; i++) coef[i] = 0;
      for (int i = 0; i < 8; i++) held[i] = 0;
      hold_thresh = 0;
      wheel_count = 4;
      mismatches = 0;
   endfunction

   function void write_reg(logic idx, logic [31:0] data);
      if (idx == CSR_HOLD_THRESH) hold_thresh = data;
      else wheel_count = data[3:0];
   endfunction

   function logic [31:0] root_of(logic [63:0] v);
      logic [63:0] root, bit_v;
      root = 0;
      bit_v = 64'd1 << 62;
      while (bit_v > v) bit_v = bit_v >> 2;
      while (bit_v != 0) begin
         if (v >= root + bit_v) begin
            v = v - (root + bit_v);
            root = (root >> 1) + bit_v;
         end else begin
            root = root >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return root[31:0];
   endfunction

   function logic [15:0] angle_of(longint wx, longint wy);
      longint x, y, xs, ys;
      logic [31:0] ang;
      x = wx * 65536;
      y = wy * 65536;
      ang = 0;
      if (x < 0) begin
         x = -x;
         y = -y;
         ang = 32'h8000_0000;
      end
      for (int i = 0; i < CORDIC_ITERATIONS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x = x + ys;
            y = y - xs;
            ang = ang + atan_units(i[4:0]);
         end else begin
            x = x - ys;
            y = y + xs;
            ang = ang - atan_units(i[4:0]);
         end
      end
      ang = ang + 32'h8000;
      return ang[31:16];
   endfunction

   function void note_command(logic action, logic signed [31:0] vx, logic signed [31:0] vy,
                              logic signed [31:0] wr, logic [2:0] cw, logic [2:0] cs,
                              logic signed [31:0] cv);
      longint cmd[3];
      longint comp[2];
      longint acc;
      int count;
      logic [31:0] speed;
      logic [15:0] dir;
      if (action == ACT_COEF_WRITE) begin
         if (cs < 6) coef[cw * 6 + cs] = cv;
         return;
      end
      cmd[0] = vx;
      cmd[1] = vy;
      cmd[2] = wr;
      count = wheel_count < 2 ? 2 : (wheel_count > 8 ? 8 : wheel_count);
      for (int k = 0; k < count; k++) begin
         for (int r = 0; r < 2; r++) begin
            acc = 0;
            for (int c = 0; c < 3; c++) acc += (longint'(coef[k * 6 + r * 3 + c]) * cmd[c]) >>> 16;
            if (acc > 64'sd2147483647) acc = 64'sd2147483647;
            if (acc < -64'sd2147483648) acc = -64'sd2147483648;
            comp[r] = acc;
         end
         speed = root_of(64'(comp[0] * comp[0]) + 64'(comp[1] * comp[1]));
         dir = held[k];
         if (speed > hold_thresh) dir = angle_of(comp[0], comp[1]);
         held[k] = dir;
         exp_index.push_back(k[2:0]);
         exp_dir.push_back(dir);
         exp_speed.push_back(speed);
         exp_last.push_back(k + 1 == count);
      end
   endfunction

   function void check_beat(logic [2:0] idx, logic [15:0] dir, logic [31:0] speed, logic last);
      logic [2:0]  ei;
      logic [15:0] ed;
      logic [31:0] es;
      logic        el;
      if (exp_index.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected rsp beat wheel %0d", idx);
         return;
      end
      ei = exp_index.pop_front();
      ed = exp_dir.pop_front();
      es = exp_speed.pop_front();
      el = exp_last.pop_front();
      if (ei !== idx || ed !== dir || es !== speed || el !== last) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: exp wheel %0d dir %0d speed %0d last %0d, got %0d %0d %0d %0d",
                     ei, $signed(ed), es, el, idx, $signed(dir), speed, last);
      end
   endfunction
endclass

module testbench;
   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0, req_ready, req_action = 0;
   logic signed [31:0] req_vel_x = 0, req_vel_y = 0, req_yaw_rate = 0, req_coef_value = 0;
   logic [2:0] req_coef_wheel = 0, req_coef_slot = 0;
   logic rsp_valid, rsp_ready = 0, rsp_last;
   logic [2:0] rsp_wheel_index;
   logic signed [15:0] rsp_wheel_dir;
   logic [31:0] rsp_wheel_speed;
   logic csr_valid = 0, csr_ready, csr_index = 0;
   logic [31:0] csr_data = 0;

   wheel_scoreboard board;
   int send_idle = 0, recv_idle = 0;
   int hold_cycles = 0;
   longint cycles = 0;

   swerve_wheel_inverse_kinematics_top DUT (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 3000000) begin
         $display("swerve_wheel_inverse_kinematics_top regression: fail");
         $finish;
      end
   end

   always @(posedge clock)
      if (!reset && rsp_valid && rsp_ready)
         board.check_beat(rsp_wheel_index, rsp_wheel_dir, rsp_wheel_speed, rsp_last);

   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ready <= 0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   task automatic send_beat(logic act, logic signed [31:0] vx, logic signed [31:0] vy,
                            logic signed [31:0] wr, logic [2:0] cw, logic [2:0] cs,
                            logic signed [31:0] cv);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_action <= act;
      req_vel_x <= vx;
      req_vel_y <= vy;
      req_yaw_rate <= wr;
      req_coef_wheel <= cw;
      req_coef_slot <= cs;
      req_coef_value <= cv;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_command(act, vx, vy, wr, cw, cs, cv);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (board.exp_index.size() != 0) @(negedge clock);
      repeat (400) @(negedge clock);
   endtask

   task automatic write_reg(logic idx, logic [31:0] data);
      drain();
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.write_reg(idx, data);
      @(negedge clock);
      csr_valid <= 0;
   endtask

   function automatic logic [31:0] rand_word();
      case ($urandom_range(5))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2: return 32'($signed($urandom_range(1 << 20)) - (1 << 19));
         3: return 0;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_velocity(logic signed [31:0] vx, logic signed [31:0] vy,
                                logic signed [31:0] wr);
      send_beat(ACT_VELOCITY, vx, vy, wr, 3'($urandom), 3'($urandom), $urandom);
   endtask

   task automatic send_coef(logic [2:0] w, logic [2:0] s, logic signed [31:0] v);
      send_beat(ACT_COEF_WRITE, $urandom, $urandom, $urandom, w, s, v);
   endtask

   task automatic random_phase(int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(3) == 0)
            send_coef(3'($urandom), 3'($urandom), rand_word());
         else
            send_velocity(rand_word(), rand_word(), rand_word());
      end
   endtask

   initial begin
      board = new();
      send_idle = 19;
      recv_idle = 54;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // Fill all coefficients, so that no command reads an unwritten entry.
      for (int w = 0; w < 8; w++)
         for (int s = 0; s < 6; s++) send_coef(3'(w), 3'(s), $urandom);
      write_reg(CSR_WHEEL_COUNT, 32'd8);
      send_velocity(0, 0, 0);
      send_velocity(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
      send_velocity(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_velocity(32'h0001_0000, 0, 0);
      send_velocity(32'hffff_0000, 32'h0000_8000, 32'hffff_ffff);
      send_coef(3'd0, 3'd6, 32'h1234);
      send_coef(3'd0, 3'd7, 32'hffff_ffff);
      send_coef(3'd7, 3'd5, 32'h0001_0000);
      send_coef(3'd0, 3'd0, 32'h7fff_ffff);
      send_coef(3'd0, 3'd1, 32'h8000_0000);
      send_velocity(32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000);
      write_reg(CSR_HOLD_THRESH, 32'hffff_ffff);
      send_velocity($urandom, $urandom, $urandom);
      write_reg(CSR_WHEEL_COUNT, 32'd0);
      send_velocity($urandom, $urandom, $urandom);
      write_reg(CSR_WHEEL_COUNT, 32'd15);
      send_velocity($urandom, $urandom, $urandom);
      write_reg(CSR_HOLD_THRESH, 32'd0);
      write_reg(CSR_WHEEL_COUNT, 32'd2);

      random_phase(15);
      hold_cycles = 3000;
      random_phase(15);
      write_reg(CSR_HOLD_THRESH, $urandom_range(1 << 20));
      write_reg(CSR_WHEEL_COUNT, 32'd4);
      send_idle = 54;
      recv_idle = 19;
      random_phase(30);
      write_reg(CSR_WHEEL_COUNT, 32'd8);
      write_reg(CSR_HOLD_THRESH, $urandom);
      send_idle = 0;
      recv_idle = 0;
      random_phase(30);
      drain();
      if (board.mismatches == 0)
         $display("swerve_wheel_inverse_kinematics_top regression: pass");
      else
         $display("swerve_wheel_inverse_kinematics_top regression: fail");
      $finish;
   end
endmodule
